FILE: rtl/fec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fec_pkg
// Shared types and constants of the edge frequency counter.
// ----------------------------------------------------------------------------
package fec_pkg;

  localparam int NUM_PINS  = 32;
  localparam int PIN_IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  localparam int OP_W     = 2;
  localparam int PIN_W    = 5;
  localparam int FREQ_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 32;
  localparam int TIME_W   = 64;

  // Item codes.
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_RESET = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

  // Scale from edges per microsecond to millihertz.
  localparam longint unsigned US_PER_S       = 1000000;
  localparam longint unsigned MILLI_PER_UNIT = 1000;
  localparam logic [TIME_W-1:0] SCALE = TIME_W'(US_PER_S * MILLI_PER_UNIT);

  // One multiplier bit and one quotient bit per cycle.
  localparam int MUL_STEPS = COUNT_W;
  localparam int DIV_STEPS = TIME_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic                valid;
    logic [FREQ_W-1:0]   freq;
    logic [STATUS_W-1:0] status;
  } fec_res_t;

endpackage

FILE: rtl/fec_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fec_muldiv
// Bit-serial scale and divide: count * SCALE / interval, saturated to 32 bits.
// ----------------------------------------------------------------------------
module fec_muldiv
  import fec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COUNT_W-1:0] count,
  input  logic [TIME_W-1:0]  interval,
  input  logic               take,
  output logic               idle,
  output fec_res_t           res
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [TIME_W-1:0]   mcand_r, mcand_nxt;
  logic [COUNT_W-1:0]  mplier_r, mplier_nxt;
  logic [TIME_W-1:0]   dq_r, dq_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [TIME_W-1:0]   divisor_r, divisor_nxt;
  logic [FREQ_W-1:0]   freq_r, freq_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [TIME_W:0]     rem_shift;
  logic [TIME_W:0]     diff;
  logic [TIME_W-1:0]   quot;

  assign rem_shift = {rem_r, dq_r[TIME_W-1]};
  assign diff      = rem_shift - {1'b0, divisor_r};
  // The dividend shifts out at the top while quotient bits enter at the bottom.
  assign quot      = {dq_r[TIME_W-2:0], ~diff[TIME_W]};

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    freq_nxt    = freq_r;
    status_nxt  = status_r;
    case (state_r)
      U_IDLE: begin
        if (start) begin
          mcand_nxt   = SCALE;
          mplier_nxt  = count;
          dq_nxt      = '0;
          rem_nxt     = '0;
          divisor_nxt = interval;
          step_nxt    = '0;
          if (interval == '0) begin
            freq_nxt   = '0;
            status_nxt = ST_ZERO;
            state_nxt  = U_DONE;
          end else begin
            state_nxt = U_MUL;
          end
        end
      end
      U_MUL: begin
        if (mplier_r[0]) begin
          dq_nxt = dq_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[TIME_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[COUNT_W-1:1]};
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        rem_nxt  = diff[TIME_W] ? rem_shift[TIME_W-1:0] : diff[TIME_W-1:0];
        dq_nxt   = quot;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          if (quot[TIME_W-1:FREQ_W] != '0) begin
            freq_nxt   = '1;
            status_nxt = ST_SAT;
          end else begin
            freq_nxt   = quot[FREQ_W-1:0];
            status_nxt = ST_OK;
          end
          state_nxt = U_DONE;
        end
      end
      U_DONE: begin
        if (take) begin
          state_nxt = U_IDLE;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    freq_r    <= freq_nxt;
    status_r  <= status_nxt;
  end

  assign idle       = (state_r == U_IDLE);
  assign res.valid  = (state_r == U_DONE);
  assign res.freq   = freq_r;
  assign res.status = status_r;

endmodule

FILE: rtl/edge_frequency_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_frequency_counter
// Per-pin rising edge counter with a reciprocal-interval frequency readout.
// ----------------------------------------------------------------------------
// Tick, edge and reset words leave the unit idle, so in_ready stays high for
// them back to back. A read of a valid pin starts a bit-serial unit that
// multiplies the edge count by 1e9 one multiplier bit per cycle and then
// divides by the elapsed microseconds one quotient bit per cycle; in_ready
// stays low from such a read, also when the interval is zero, until the result
// has moved into the output register, which may first have to empty. The
// output register lets a new word be accepted while a finished result still
// waits on out_ready.
module edge_frequency_counter
  import fec_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [PIN_W-1:0]    in_pin,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FREQ_W-1:0]   out_freq_millihertz,
  output logic [STATUS_W-1:0] out_status
);

  logic [TIME_W-1:0]    now_r;
  logic [COUNT_W-1:0]   counts_r [NUM_PINS];
  logic [TIME_W-1:0]    last_r   [NUM_PINS];
  logic                 out_valid_r;
  logic [FREQ_W-1:0]    out_freq_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic [PIN_W:0]       pin_ext;
  logic [PIN_IDX_W-1:0] pin_idx;
  logic                 pin_ok;
  logic                 accept;
  logic                 start;
  logic                 unit_idle;
  logic                 take;
  logic [COUNT_W-1:0]   cur_count;
  logic [TIME_W-1:0]    interval;
  fec_res_t             res;

  assign pin_ext   = {1'b0, in_pin};
  assign pin_idx   = pin_ext[PIN_IDX_W-1:0];
  assign pin_ok    = ({1'b0, pin_ext} < (PIN_W + 2)'(NUM_PINS));
  assign in_ready  = unit_idle;
  assign accept    = in_valid && in_ready;
  assign start     = accept && (in_op == OP_READ) && pin_ok;
  assign cur_count = counts_r[pin_idx];
  assign interval  = now_r - last_r[pin_idx];
  assign take      = res.valid && (!out_valid_r || out_ready);

  fec_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .count    (cur_count),
    .interval (interval),
    .take     (take),
    .idle     (unit_idle),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        counts_r[i] <= '0;
        last_r[i]   <= '0;
      end
    end else if (accept) begin
      case (in_op)
        OP_TICK: now_r <= now_r + 1'b1;
        OP_EDGE: begin
          if (pin_ok && cur_count != '1) begin
            counts_r[pin_idx] <= cur_count + 1'b1;
          end
        end
        OP_READ, OP_RESET: begin
          if (pin_ok) begin
            counts_r[pin_idx] <= '0;
            last_r[pin_idx]   <= now_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      out_freq_r   <= res.freq;
      out_status_r <= res.status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_freq_millihertz = out_freq_r;
  assign out_status          = out_status_r;

  // A read of a valid pin must hold off the next word while the unit runs.
  a_read_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("input accepted while a read is in progress");

  a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ZERO) |-> (out_freq_millihertz == '0))
    else $error("zero interval result carries a nonzero frequency");

  a_sat_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SAT) |-> (out_freq_millihertz == '1))
    else $error("saturated result is not all ones");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_ZERO || out_status == ST_SAT))
    else $error("undefined status code on the result");

  // A finished result is only moved into an empty or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_freq_millihertz) && $stable(out_status)))
    else $error("result overwritten before it was taken");

endmodule

FILE: bench/edge_frequency_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_frequency_counter_tb
// Self-checking bench for the per-pin edge frequency counter. A scoreboard
// follows the microsecond clock, the edge counts and the read times of every
// pin, and predicts each frequency reading. Each reading that comes out is
// checked field by field in order. Directed words come first: zero interval,
// saturated quotient, the largest unsaturated value, a read of zero edges and
// a pin reset. Random bursts with random gaps follow, against a receiver that
// stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module edge_frequency_counter_tb
  import fec_pkg::*;
();

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_WORDS = 930;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [TIME_W-1:0] MILLIHERTZ_PER_EDGE_US = 64'd1_000_000_000;

  typedef struct {
    logic [FREQ_W-1:0]   freq;
    logic [STATUS_W-1:0] status;
  } reading_t;

  class freq_scoreboard;
    logic [TIME_W-1:0]  now_us;
    logic [COUNT_W-1:0] edge_cnt [NUM_PINS];
    logic [TIME_W-1:0]  last_read_us [NUM_PINS];
    reading_t           pending[$];
    int                 errors;
    int                 words_accepted;

    function new();
      now_us = '0;
      foreach (edge_cnt[i]) begin
        edge_cnt[i]     = '0;
        last_read_us[i] = '0;
      end
      errors         = 0;
      words_accepted = 0;
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [PIN_W-1:0] pin);
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  span;
      logic [TIME_W-1:0]  quotient;
      reading_t           r;
      words_accepted++;
      if (op == OP_TICK) begin
        now_us = now_us + 1'b1;
        return;
      end
      if (int'(pin) >= NUM_PINS) return;
      case (op)
        OP_EDGE: begin
          if (edge_cnt[pin] != '1) edge_cnt[pin] = edge_cnt[pin] + 1'b1;
        end
        OP_RESET: begin
          edge_cnt[pin]     = '0;
          last_read_us[pin] = now_us;
        end
        default: begin
          count             = edge_cnt[pin];
          span              = now_us - last_read_us[pin];
          edge_cnt[pin]     = '0;
          last_read_us[pin] = now_us;
          if (span == '0) begin
            r.freq   = '0;
            r.status = ST_ZERO;
          end else begin
            quotient = (TIME_W'(count) * MILLIHERTZ_PER_EDGE_US) / span;
            if (quotient > TIME_W'({FREQ_W{1'b1}})) begin
              r.freq   = '1;
              r.status = ST_SAT;
            end else begin
              r.freq   = quotient[FREQ_W-1:0];
              r.status = ST_OK;
            end
          end
          pending.push_back(r);
        end
      endcase
    endfunction

    function void check_result(logic [FREQ_W-1:0] freq, logic [STATUS_W-1:0] status);
      reading_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected reading: freq_millihertz %0d, status %0d", freq, status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (freq !== exp_r.freq) begin
        $error("freq_millihertz: expected %0d, actual %0d", exp_r.freq, freq);
        errors++;
      end
      if (status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, status);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op     = OP_TICK;
  logic [PIN_W-1:0]    in_pin    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [FREQ_W-1:0]   out_freq_millihertz;
  logic [STATUS_W-1:0] out_status;

  freq_scoreboard sb = new();
  int             cycle_count = 0;

  edge_frequency_counter DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_pin              (in_pin),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_freq_millihertz (out_freq_millihertz),
    .out_status          (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_freq_millihertz, out_status);
  end

  // The valid stays high across back-to-back words; only a gap lowers it.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [PIN_W-1:0] pin);
    @(negedge clk);
    in_valid <= 1'b1;
    in_op    <= op;
    in_pin   <= pin;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, pin);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_edges(input logic [PIN_W-1:0] pin, input int n);
    repeat (n) send_word(OP_EDGE, pin);
  endtask

  task automatic run_directed();
    send_word(OP_READ, 5'd0);    // nothing has elapsed since reset
    send_word(OP_TICK, 5'd0);
    send_edges(5'd31, 4);
    send_word(OP_READ, 5'd31);   // largest value that still fits
    send_edges(5'd31, 5);
    send_word(OP_TICK, 5'd31);
    send_word(OP_READ, 5'd31);   // quotient saturates
    send_word(OP_READ, 5'd31);   // back-to-back read, zero interval
    send_edges(5'd5, 2);
    send_word(OP_RESET, 5'd5);
    send_word(OP_EDGE, 5'd5);
    send_word(OP_TICK, 5'd0);
    send_word(OP_READ, 5'd5);
    send_word(OP_TICK, 5'd0);
    send_word(OP_READ, 5'd1);    // no edges seen on this pin
  endtask

  task automatic run_random();
    logic [PIN_W-1:0] hot_pins [4];
    int               sent;
    int               burst;
    int               tick_pct;
    int               roll;
    logic [OP_W-1:0]  op;
    logic [PIN_W-1:0] pin;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      // Each burst works a few pins at its own edge rate, so readings
      // range from far below the limit to saturated.
      foreach (hot_pins[i]) hot_pins[i] = PIN_W'($urandom_range(0, NUM_PINS - 1));
      tick_pct = $urandom_range(10, 85);
      burst    = $urandom_range(1, 40);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) pin = PIN_W'($urandom_range(0, 31));
        else pin = hot_pins[$urandom_range(0, 3)];
        if (roll < 8) op = OP_READ;
        else if (roll < 11) op = OP_RESET;
        else if ($urandom_range(0, 99) < tick_pct) op = OP_TICK;
        else op = OP_EDGE;
        send_word(op, pin);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
  endtask

  initial begin : receiver
    int  mode;
    int  phase_left;
    bit  held;
    mode       = 0;
    phase_left = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      // One long hold-off lets the output register and the divider fill up.
      if (!held && sb.words_accepted >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(10, 80);
      end
      phase_left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    idle_gap(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
